>>> rtl/core/fla_pkg.sv
// shared types and constants of the free-list entry allocator
`default_nettype none

package fla_pkg;

   // request and result field widths
   localparam int CMD_W   = 2;
   localparam int INDEX_W = 8;
   localparam int GRANT_W = 8;

   // request command codes
   typedef enum logic [CMD_W-1:0] {
      CMD_ALLOCATE = 2'd0,
      CMD_FREE     = 2'd1,
      CMD_FREE_ALL = 2'd2
   } cmd_type;

   // controller sequencing
   typedef enum logic [1:0] {
      ST_SWEEP,
      ST_IDLE,
      ST_RESP
   } state_type;

   // finished result handed from the controller to the output register
   typedef struct packed {
      logic               valid;
      logic [GRANT_W-1:0] granted;
      logic               status;
   } result_type;

endpackage

`default_nettype wire

>>> rtl/core/fla_ram.sv
// generic single-port-write, single-port-read ram with registered read
`default_nettype none

module fla_ram #(
   parameter int WIDTH = 9,
   parameter int DEPTH = 256
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic                     rd_en,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic      [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // write port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   // registered read, holds until the next read
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

>>> rtl/core/fla_ctrl.sv
// free list controller: head pointer, link memory sequencing and relink sweep
`default_nettype none

module fla_ctrl #(
   parameter int POOL_ENTRIES = 256
) (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic                          req_valid,
   output logic                               req_ready,
   input  wire fla_pkg::cmd_type              req_command,
   input  wire logic [fla_pkg::INDEX_W-1:0]   req_index,
   input  wire logic                          slot_free,
   output fla_pkg::result_type                result,
   output logic                               mem_wr_en,
   output logic [$clog2(POOL_ENTRIES)-1:0]    mem_wr_addr,
   output logic [$clog2(POOL_ENTRIES+1)-1:0]  mem_wr_data,
   output logic                               mem_rd_en,
   output logic [$clog2(POOL_ENTRIES)-1:0]    mem_rd_addr,
   input  wire logic [$clog2(POOL_ENTRIES+1)-1:0] mem_rd_data
);

   import fla_pkg::*;

   localparam int IW = $clog2(POOL_ENTRIES);
   localparam int LW = $clog2(POOL_ENTRIES + 1);
   localparam logic [LW-1:0] LINK_NULL  = LW'(POOL_ENTRIES);
   localparam logic [IW-1:0] LAST_ENTRY = IW'(POOL_ENTRIES - 1);

   state_type          state_ff, state_in;
   logic [LW-1:0]      head_ff, head_in;
   logic [IW-1:0]      sweep_ff, sweep_in;
   logic               pending_ff, pending_in;
   logic               load_head_ff, load_head_in;
   logic [GRANT_W-1:0] granted_ff, granted_in;
   logic               status_ff, status_in;
   logic               in_range;

   // free of an index beyond the pool is ignored
   assign in_range = 32'(req_index) < 32'(POOL_ENTRIES);

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_SWEEP;
         head_ff      <= '0;
         sweep_ff     <= '0;
         pending_ff   <= 1'b0;
         load_head_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         head_ff      <= head_in;
         sweep_ff     <= sweep_in;
         pending_ff   <= pending_in;
         load_head_ff <= load_head_in;
      end
   end

   // result payload
   always_ff @(posedge clock) begin
      granted_ff <= granted_in;
      status_ff  <= status_in;
   end

   // next state and memory accesses
   always_comb begin
      state_in       = state_ff;
      head_in        = head_ff;
      sweep_in       = sweep_ff;
      pending_in     = pending_ff;
      load_head_in   = load_head_ff;
      granted_in     = granted_ff;
      status_in      = status_ff;
      req_ready      = 1'b0;
      mem_wr_en      = 1'b0;
      mem_wr_addr    = sweep_ff;
      mem_wr_data    = LW'(sweep_ff) + LW'(1);
      mem_rd_en      = 1'b0;
      mem_rd_addr    = head_ff[IW-1:0];
      result.valid   = 1'b0;
      result.granted = granted_ff;
      result.status  = status_ff;

      case (state_ff)
         // relink entry i to i+1, the last one gets the null link
         ST_SWEEP: begin
            mem_wr_en = 1'b1;
            sweep_in  = sweep_ff + IW'(1);
            if (sweep_ff == LAST_ENTRY) begin
               sweep_in   = '0;
               head_in    = '0;
               pending_in = 1'b0;
               state_in   = pending_ff ? ST_RESP : ST_IDLE;
            end
         end

         // take one request
         ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               granted_in = '0;
               status_in  = 1'b0;
               state_in   = ST_RESP;
               case (req_command)
                  CMD_ALLOCATE: begin
                     if (head_ff == LINK_NULL) begin
                        status_in = 1'b1;
                     end else begin
                        granted_in   = GRANT_W'(32'(head_ff));
                        mem_rd_en    = 1'b1;
                        load_head_in = 1'b1;
                     end
                  end
                  CMD_FREE: begin
                     if (in_range) begin
                        mem_wr_en   = 1'b1;
                        mem_wr_addr = IW'(req_index);
                        mem_wr_data = head_ff;
                        head_in     = LW'(req_index);
                     end
                  end
                  CMD_FREE_ALL: begin
                     sweep_in   = '0;
                     pending_in = 1'b1;
                     state_in   = ST_SWEEP;
                  end
                  default: begin
                  end
               endcase
            end
         end

         // pop completes from the link read while the result is offered
         ST_RESP: begin
            if (load_head_ff) begin
               head_in      = mem_rd_data;
               load_head_in = 1'b0;
            end
            result.valid = 1'b1;
            if (slot_free) begin
               state_in = ST_IDLE;
            end
         end

         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

endmodule

`default_nettype wire

>>> rtl/core/free_list_entry_allocator.sv
// Free-list entry allocator: LIFO pool of entries in a link memory with registered read.
// Allocate and free pass their result through the response state and the output
// register; free all first relinks the whole pool, one link memory write per entry.
// A new request is taken only once the last result has entered the output register.
// Reset: synchronous; a relink pass over every entry follows, with no request
// accepted until it ends; then head is entry 0 and entry i links i+1.
`default_nettype none

module free_list_entry_allocator #(
   parameter int POOL_ENTRIES = 256
) (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_tvalid,
   output logic             req_tready,
   input  wire logic [15:0] req_tdata,   // [1:0] command, [9:2] entry_index, rest zero
   output logic             rsp_tvalid,
   input  wire logic        rsp_tready,
   output logic      [15:0] rsp_tdata    // [7:0] granted_index, [8] status, rest zero
);

   import fla_pkg::*;

   localparam int IW = $clog2(POOL_ENTRIES);
   localparam int LW = $clog2(POOL_ENTRIES + 1);

   result_type         result;
   logic               slot_free;
   logic               mem_wr_en;
   logic [IW-1:0]      mem_wr_addr;
   logic [LW-1:0]      mem_wr_data;
   logic               mem_rd_en;
   logic [IW-1:0]      mem_rd_addr;
   logic [LW-1:0]      mem_rd_data;
   logic               rsp_valid_ff;
   logic [GRANT_W-1:0] rsp_granted_ff;
   logic               rsp_status_ff;

   // output register is free when empty or being drained
   assign slot_free = !rsp_valid_ff || rsp_tready;

   fla_ctrl #(
      .POOL_ENTRIES (POOL_ENTRIES)
   ) u_ctrl (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_tvalid),
      .req_ready   (req_tready),
      .req_command (cmd_type'(req_tdata[CMD_W-1:0])),
      .req_index   (req_tdata[CMD_W+INDEX_W-1:CMD_W]),
      .slot_free   (slot_free),
      .result      (result),
      .mem_wr_en   (mem_wr_en),
      .mem_wr_addr (mem_wr_addr),
      .mem_wr_data (mem_wr_data),
      .mem_rd_en   (mem_rd_en),
      .mem_rd_addr (mem_rd_addr),
      .mem_rd_data (mem_rd_data)
   );

   fla_ram #(
      .WIDTH (LW),
      .DEPTH (POOL_ENTRIES)
   ) u_links (
      .clock   (clock),
      .wr_en   (mem_wr_en),
      .wr_addr (mem_wr_addr),
      .wr_data (mem_wr_data),
      .rd_en   (mem_rd_en),
      .rd_addr (mem_rd_addr),
      .rd_data (mem_rd_data)
   );

   // response output register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (slot_free) begin
         rsp_valid_ff <= result.valid;
      end
   end

   always_ff @(posedge clock) begin
      if (slot_free && result.valid) begin
         rsp_granted_ff <= result.granted;
         rsp_status_ff  <= result.status;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {7'd0, rsp_status_ff, rsp_granted_ff};

endmodule

`default_nettype wire
